>>> sv/ptt_pkg.sv
// shared types and constants for the periodic task timer table
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int FIELD_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = 5;

    localparam logic [FIELD_W-1:0] NOT_SET = 16'hFFFF;

    // operation codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_ADD    = 2'd0;
    localparam action_t ACT_DELETE = 2'd1;
    localparam action_t ACT_TICK   = 2'd2;
    localparam action_t ACT_SCAN   = 2'd3;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_DUP   = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        action_t              action;
        logic [FIELD_W-1:0]   task_key;
        logic [FIELD_W-1:0]   period;
        logic [FIELD_W-1:0]   task_tag;
    } ptt_in_t;

    typedef struct packed {
        status_t              status;
        logic                 dispatch_valid;
        logic [SLOT_W-1:0]    slot;
        logic [FIELD_W-1:0]   dispatched_tag;
        logic [COUNT_W-1:0]   task_count;
        logic                 last;
    } ptt_out_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   key;
        logic [FIELD_W-1:0]   tag;
        logic [FIELD_W-1:0]   period;
        logic [FIELD_W-1:0]   countdown;
    } entry_t;

endpackage

>>> sv/ptt_in_if.sv
// operation channel: valid/ready with one operation per beat
`timescale 1ns / 1ps

interface ptt_in_if;
    import ptt_pkg::*;

    logic    valid;
    logic    ready;
    ptt_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ptt_out_if.sv
// result channel: valid/ready with one result per beat
`timescale 1ns / 1ps

interface ptt_out_if;
    import ptt_pkg::*;

    logic     valid;
    logic     ready;
    ptt_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/periodic_task_timer_table.sv
// periodic task timer table: task store, sequencer and result register
//
// task_in takes one operation per beat (add, delete, tick, schedule scan).
// result_out gives the results of that operation, one per beat, the final
// one marked by last. Add, delete and tick give one result; a scan gives one
// dispatch per due task in table order (up to 16), or one empty result.
// The table sits in a single-port-write, one-read memory; each entry is
// visited by a read, then a compare/update in the shared unit. An add that
// meets its key stops the search there; an add to a full table or any
// operation on an empty table goes straight to its final result, and a
// delete that finds its key moves each later entry down one place (read,
// then write) before it ends.
// task_in is ready only between operations, so one operation is in work at
// a time and a new one is taken only after the last one has ended.
// A stalled result_out holds the result register; a scan then waits before
// taking the next due task, and an operation waits at its end for the
// register to free up. Reset empties the table at once (count goes to zero),
// no clearing pass is needed.
`timescale 1ns / 1ps

module periodic_task_timer_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ptt_in_if.sink    task_in,
    ptt_out_if.source result_out
);
    import ptt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [N_W-1:0]   MAX_C   = N_W'(MAX_RESULTS);

    // task store
    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;
    logic   [IDX_W-1:0] rd_addr;
    logic               mem_we;
    logic   [IDX_W-1:0] mem_waddr;
    entry_t             mem_wdata;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [N_W-1:0]      n_reg, n_next;
    ptt_in_t             op_reg, op_next;
    status_t             status_reg, status_next;
    logic                found_reg, found_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [FIELD_W-1:0]  pend_tag_reg, pend_tag_next;
    logic                out_valid_reg, out_valid_next;
    ptt_out_t            out_data_reg, out_data_next;

    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    idx_ext;
    logic [CNT_W-1:0]    idx_plus1;
    logic [CNT_W-1:0]    idx_plus2;
    logic                is_last;
    logic                key_match;
    logic                due;
    logic                scan_stall;
    logic                add_ok;
    logic [CNT_W-1:0]    count_after;

    assign accept     = task_in.valid && task_in.ready;
    assign out_free   = !out_valid_reg || result_out.ready;
    assign idx_ext    = CNT_W'(idx_reg);
    assign idx_plus1  = idx_ext + CNT_W'(1);
    assign idx_plus2  = idx_ext + CNT_W'(2);
    assign is_last    = (idx_plus1 == count_reg);
    assign key_match  = (rdata_reg.key == op_reg.task_key);
    assign due        = (rdata_reg.countdown == '0) && (rdata_reg.key != '0);
    assign scan_stall = due && pend_valid_reg && !out_free;
    assign add_ok     = (op_reg.action == ACT_ADD) && (status_reg == ST_DONE);
    assign rd_addr    = (state_reg == S_SHIFT_RD) ? IDX_W'(idx_plus1) : idx_reg;

    // table size after the current operation
    always_comb
    begin
        count_after = count_reg;
        if (add_ok)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if ((op_reg.action == ACT_DELETE) && found_reg)
        begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    assign task_in.ready   = (state_reg == S_IDLE);
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg == '0 ||
                        (task_in.data.action == ACT_ADD && count_reg == DEPTH_C))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (op_reg.action)
                    ACT_ADD:
                    begin
                        state_next = (key_match || is_last) ? S_FINISH : S_READ;
                    end
                    ACT_DELETE:
                    begin
                        if (key_match)
                        begin
                            state_next = is_last ? S_FINISH : S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = is_last ? S_FINISH : S_READ;
                        end
                    end
                    ACT_TICK:
                    begin
                        state_next = is_last ? S_FINISH : S_READ;
                    end
                    default:
                    begin
                        if (!scan_stall)
                        begin
                            if (is_last || (due && (n_reg + N_W'(1)) == MAX_C))
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = (idx_plus2 < count_reg) ? S_SHIFT_RD : S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control and shared compare/decrement unit
    always_comb
    begin
        idx_next        = idx_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = task_in.data;
                    idx_next        = '0;
                    n_next          = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    if (task_in.data.action == ACT_ADD && count_reg == DEPTH_C)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (task_in.data.action == ACT_DELETE && count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                    end
                end
            end
            S_EXEC:
            begin
                case (op_reg.action)
                    ACT_ADD:
                    begin
                        if (key_match)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (!is_last)
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (key_match)
                        begin
                            found_next = 1'b1;
                        end
                        else if (!is_last)
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    ACT_TICK:
                    begin
                        if (rdata_reg.countdown != NOT_SET && rdata_reg.countdown != '0)
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.countdown = rdata_reg.countdown - FIELD_W'(1);
                        end
                        if (!is_last)
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        if (!scan_stall)
                        begin
                            if (due)
                            begin
                                // reload and hold the dispatch until its successor is known
                                mem_we              = 1'b1;
                                mem_wdata.countdown = rdata_reg.period;
                                if (pend_valid_reg)
                                begin
                                    out_valid_next              = 1'b1;
                                    out_data_next.status        = ST_DONE;
                                    out_data_next.dispatch_valid = 1'b1;
                                    out_data_next.slot          = SLOT_W'(pend_slot_reg);
                                    out_data_next.dispatched_tag = pend_tag_reg;
                                    out_data_next.task_count    = COUNT_W'(count_reg);
                                    out_data_next.last          = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_slot_next  = idx_reg;
                                pend_tag_next   = rdata_reg.tag;
                                n_next          = n_reg + N_W'(1);
                            end
                            if (!is_last)
                            begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end
                endcase
            end
            S_SHIFT_WR:
            begin
                // move the following entry down one place
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                idx_next  = idx_reg + IDX_W'(1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.status     = status_reg;
                    out_data_next.task_count = COUNT_W'(count_after);
                    out_data_next.last       = 1'b1;
                    if (op_reg.action == ACT_SCAN && pend_valid_reg)
                    begin
                        out_data_next.dispatch_valid = 1'b1;
                        out_data_next.slot           = SLOT_W'(pend_slot_reg);
                        out_data_next.dispatched_tag = pend_tag_reg;
                    end
                    else
                    begin
                        out_data_next.dispatch_valid = 1'b0;
                        out_data_next.slot           = '0;
                        out_data_next.dispatched_tag = '0;
                    end
                    if (add_ok)
                    begin
                        mem_we              = 1'b1;
                        mem_waddr           = IDX_W'(count_reg);
                        mem_wdata.key       = op_reg.task_key;
                        mem_wdata.tag       = op_reg.task_tag;
                        mem_wdata.period    = op_reg.period;
                        mem_wdata.countdown = op_reg.period;
                    end
                    count_next      = count_after;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // task store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            status_reg     <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            status_reg     <= status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        out_data_reg  <= out_data_next;
    end

    // table never holds more tasks than it has rows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("task count above table depth");

    // a scan never dispatches more than the result limit
    a_dispatch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_C)
        else $error("dispatch count above limit");

    // a held dispatch belongs to a scan
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (op_reg.action == ACT_SCAN))
        else $error("pending dispatch outside a scan");

    // a successful add grows the table by one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free && add_ok)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("add did not grow the table");

    // every operation ends in a final result beat
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=> (out_valid_reg && out_data_reg.last))
        else $error("operation ended without a final result");

endmodule
